// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top module of the category probability block.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked implication with reset disable.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be true.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- rtl/core/ncp_pkg.sv -----
// Types and constants of the nominal category probability block.
// No dependencies; the interfaces, exp cell, exp chain, divider and top module import it.
package ncp_pkg;

  localparam int unsigned COEF_W      = 16;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned CAT_W       = 3;
  localparam int unsigned CNT_W       = 2;
  localparam int unsigned ACC_W       = 36;
  localparam int unsigned Z_W         = 29;
  localparam int unsigned FRAC_W      = 24;
  localparam int unsigned TERM_W      = 25;
  localparam int unsigned SUM_W       = 26;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned E_W         = 36;
  localparam int unsigned DEN_W       = 40;
  localparam int unsigned PROB_W      = 16;
  localparam int unsigned RECIP_W     = 29;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned SERIES_LEN  = 10;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 3;

  // log2(e) in Q.30 and ln(2) in Q.24.
  localparam logic [30:0]       LOG2E_Q30 = 31'd1549082005;
  localparam logic [FRAC_W-1:0] LN2_Q24   = 24'd11629080;
  localparam logic [TERM_W-1:0] ONE_Q24   = 25'h100_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CATS = 2'd0,
    CFG_DIMS = 2'd1,
    CFG_COVS = 2'd2
  } ncp_cfg_e;

  // One slot of the power series chain.
  typedef struct packed {
    logic                      valid;
    logic                      num;
    logic [TERM_W-1:0]         term;
    logic [FRAC_W-1:0]         g;
    logic [SUM_W-1:0]          sum;
    logic signed [SHIFT_W-1:0] n;
  } ncp_series_t;

endpackage

// ----- rtl/core/ncp_if.sv -----
// Valid/ready channel interfaces for input and result transactions.
// Depends on ncp_pkg for field widths.
interface ncp_in_if;
  import ncp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [ADDR_W-1:0]        coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [COEF_W-1:0] theta_first;
  logic signed [COEF_W-1:0] theta_second;
  logic signed [COEF_W-1:0] cov_first;
  logic signed [COEF_W-1:0] cov_second;
  logic [CAT_W-1:0]         response;
  modport source (output valid, kind, coef_index, coef_value, theta_first, theta_second,
                  cov_first, cov_second, response, input ready);
  modport sink (input valid, kind, coef_index, coef_value, theta_first, theta_second,
                cov_first, cov_second, response, output ready);
endinterface

interface ncp_out_if;
  import ncp_pkg::*;
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] probability;
  logic              bad_response;
  modport source (output valid, probability, bad_response, input ready);
  modport sink (input valid, probability, bad_response, output ready);
endinterface

// ----- rtl/core/ncp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ncp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/core/ncp_exp_cell.sv -----
// One cell of the 2^f power series: next term = floor(floor(term*g/2^24)/K).
// Depends on ncp_pkg. Two register stages per cell.
module ncp_exp_cell #(
  parameter int unsigned K = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ncp_pkg::ncp_series_t cell_i,
  output ncp_pkg::ncp_series_t cell_o
);
  import ncp_pkg::*;

  // Reciprocal of K, exact for dividends below 2^24.
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + K - 1) / K);

  logic [TERM_W+FRAC_W-1:0]  prod1;
  logic [TERM_W+RECIP_W-1:0] prod2;
  ncp_series_t               mid_d;
  ncp_series_t               mid_q;
  ncp_series_t               out_d;
  ncp_series_t               out_q;

  assign prod1 = (TERM_W+FRAC_W)'(cell_i.term) * (TERM_W+FRAC_W)'(cell_i.g);
  assign prod2 = (TERM_W+RECIP_W)'(mid_q.term) * (TERM_W+RECIP_W)'(RECIP);

  // Stage one multiplies by g, stage two divides by K and adds into the sum.
  always_comb begin
    mid_d      = cell_i;
    mid_d.term = prod1[TERM_W+FRAC_W-1:FRAC_W];
    out_d      = mid_q;
    out_d.term = prod2[RECIP_SHIFT +: TERM_W];
    out_d.sum  = mid_q.sum + SUM_W'(prod2[RECIP_SHIFT +: TERM_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      out_q <= '0;
    end else begin
      mid_q <= mid_d;
      out_q <= out_d;
    end
  end

  assign cell_o = out_q;
endmodule

// ----- rtl/core/ncp_exp_chain.sv -----
// Pipelined exp() of a saturated Q.24 logit through a chain of series cells.
// Depends on ncp_pkg and ncp_exp_cell. One logit per cycle.
module ncp_exp_chain (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  z_valid_i,
  input  logic signed [ncp_pkg::Z_W-1:0] z_i,
  input  logic                  z_num_i,
  output logic                  e_valid_o,
  output logic [ncp_pkg::E_W-1:0] e_o,
  output logic                  e_num_o
);
  import ncp_pkg::*;

  logic                 bv_q;
  logic                 bnum_q;
  logic signed [60:0]   bprod_q;
  logic signed [60:0]   bprod_d;
  logic [2*FRAC_W-1:0]  gprod;
  ncp_series_t          link0_d;
  ncp_series_t          link0_q;
  ncp_series_t          link [SERIES_LEN+1];
  logic [SHIFT_W-1:0]   rshift;
  logic [E_W+SUM_W-1:0] lshifted;
  logic                 ev_q;
  logic                 enum_q;
  logic [E_W-1:0]       e_q;

  // Scale to base two: x * log2(e).
  assign bprod_d = 61'(z_i) * 61'($signed({1'b0, LOG2E_Q30}));
  // Fraction bits times ln(2) give the series argument.
  assign gprod = (2*FRAC_W)'(bprod_q[53:30]) * (2*FRAC_W)'(LN2_Q24);

  // Head of the series chain.
  always_comb begin
    link0_d       = '0;
    link0_d.valid = bv_q;
    link0_d.num   = bnum_q;
    link0_d.term  = ONE_Q24;
    link0_d.sum   = SUM_W'(ONE_Q24);
    link0_d.g     = gprod[2*FRAC_W-1:FRAC_W];
    link0_d.n     = bprod_q[58:54];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q    <= 1'b0;
      link0_q <= '0;
    end else begin
      bv_q    <= z_valid_i;
      link0_q <= link0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bnum_q  <= z_num_i;
    bprod_q <= bprod_d;
  end

  assign link[0] = link0_q;

  // Ten series terms, one cell each.
  for (genvar i = 0; i < SERIES_LEN; i++) begin : g_cell
    ncp_exp_cell #(.K(i + 1)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[i]),
      .cell_o (link[i+1])
    );
  end

  // Apply the integer power of two.
  assign rshift   = SHIFT_W'(-link[SERIES_LEN].n);
  assign lshifted = (E_W+SUM_W)'(link[SERIES_LEN].sum) << link[SERIES_LEN].n[SHIFT_W-2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
    end else begin
      ev_q <= link[SERIES_LEN].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    enum_q <= link[SERIES_LEN].num;
    if (link[SERIES_LEN].n[SHIFT_W-1]) begin
      e_q <= E_W'(link[SERIES_LEN].sum >> rshift);
    end else begin
      e_q <= lshifted[E_W-1:0];
    end
  end

  assign e_valid_o = ev_q;
  assign e_o       = e_q;
  assign e_num_o   = enum_q;
endmodule

// ----- rtl/core/ncp_div.sv -----
// Restoring divider: floor(num * 2^16 / den), saturated when num >= den.
// Depends on ncp_pkg. One quotient bit per cycle.
module ncp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ncp_pkg::DEN_W-1:0] num_i,
  input  logic [ncp_pkg::DEN_W-1:0] den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [ncp_pkg::PROB_W-1:0] quot_o
);
  import ncp_pkg::*;

  localparam int unsigned STEP_W = $clog2(PROB_W + 1);

  logic                busy_q;
  logic                done_q;
  logic                done_d;
  logic [STEP_W-1:0]   cnt_q;
  logic [DEN_W:0]      rem_q;
  logic [DEN_W:0]      rem2;
  logic [DEN_W-1:0]    den_q;
  logic [PROB_W-1:0]   quot_q;
  logic                fits;

  assign rem2 = {rem_q[DEN_W-1:0], 1'b0};
  assign fits = rem2 >= {1'b0, den_q};

  // Done after the last step, or at once when the probability saturates.
  assign done_d = (start_i && !busy_q && (num_i >= den_i)) ||
                  (busy_q && (cnt_q == STEP_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= done_d;
      if (start_i && !busy_q) begin
        // Probability of one or more saturates at once.
        if (num_i < den_i) begin
          busy_q <= 1'b1;
          cnt_q  <= STEP_W'(PROB_W);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= (num_i >= den_i) ? '1 : '0;
    end else if (busy_q) begin
      rem_q  <= fits ? (rem2 - {1'b0, den_q}) : rem2;
      quot_q <= {quot_q[PROB_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ----- rtl/core/nominal_category_probability.sv -----
// Nominal-response category probability, one evaluate transaction at a time.
// Coefficients are read one per cycle, the logits pass the exp cell chain and the 16-step
// divider forms the quotient; the next transaction is taken when the previous one has
// left the core.
// Reset clears control and configuration (C=2, D=1, J=0); the coefficient
// table stays undefined until written.
`include "assert_macros.svh"

module nominal_category_probability #(
  parameter int unsigned MAX_CATEGORIES = 7,
  parameter int unsigned MAX_DIMS       = 2,
  parameter int unsigned MAX_COVARIATES = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ncp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ncp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ncp_in_if.sink                         in_i,
  ncp_out_if.source                      out_o
);
  import ncp_pkg::*;

  localparam int unsigned DIM_LIM = (MAX_DIMS < 2) ? MAX_DIMS : 2;
  localparam int unsigned COV_LIM = (MAX_COVARIATES < 2) ? MAX_COVARIATES : 2;
  localparam logic signed [ACC_W-1:0] ZLIM = ACC_W'(64'sd1 << 27);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_DIV,
    S_PUT
  } state_e;

  typedef struct packed {
    logic valid;
    logic cov;
    logic first;
    logic last;
    logic num;
  } tag_t;

  state_e                   state_q;
  logic [CAT_W-1:0]         cats_q;
  logic [CNT_W-1:0]         dims_q;
  logic [CNT_W-1:0]         covs_q;
  logic [CAT_W-1:0]         cats_eff;
  logic [CNT_W-1:0]         dims_eff;
  logic [CNT_W-1:0]         covs_eff;
  logic [CAT_W-1:0]         item_cats_q;
  logic [CNT_W-1:0]         item_dims_q;
  logic [CNT_W-1:0]         item_covs_q;
  logic signed [COEF_W-1:0] theta0_q, theta1_q, cov0_q, cov1_q;
  logic [CAT_W-1:0]         resp_q;
  logic                     in_acc;
  logic                     load_acc;
  logic                     eval_acc;
  logic                     bad_resp;

  // Issue counters.
  logic                     phase_cov_q;
  logic [CAT_W-1:0]         k_q;
  logic [CNT_W-1:0]         d_q;
  logic [CNT_W-1:0]         j_q;
  logic [7:0]               addr_full;
  logic signed [COEF_W-1:0] op_d;
  tag_t                     tag_d;
  logic                     issue;

  // Multiply-accumulate pipeline.
  logic [COEF_W-1:0]          ram_rdata;
  tag_t                       tag_r_q, tag_p_q;
  logic signed [COEF_W-1:0]   op_r_q;
  logic signed [2*COEF_W-1:0] prod_q;
  logic signed [ACC_W-1:0]    acc_q, cov_sum_q, acc_next;
  logic                       zv_q, znum_q;
  logic signed [Z_W-1:0]      z_q;

  // Exp results and division.
  logic                 e_valid, e_num;
  logic [E_W-1:0]       e_val;
  logic [DEN_W-1:0]     den_q, num_q;
  logic [CAT_W-1:0]     done_cnt_q;
  logic                 div_start, div_busy, div_done;
  logic [PROB_W-1:0]    div_quot;
  logic [PROB_W-1:0]    res_prob_q;
  logic                 res_bad_q;
  logic                 out_valid_q;
  logic [PROB_W-1:0]    out_prob_q;
  logic                 out_bad_q;
  logic                 put_fire;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_acc   = in_acc && !in_i.kind;
  assign eval_acc   = in_acc && in_i.kind;

  assign cats_eff = (int'(cats_q) > MAX_CATEGORIES) ? CAT_W'(MAX_CATEGORIES) : cats_q;
  assign dims_eff = (int'(dims_q) > DIM_LIM) ? CNT_W'(DIM_LIM) : dims_q;
  assign covs_eff = (int'(covs_q) > COV_LIM) ? CNT_W'(COV_LIM) : covs_q;
  assign bad_resp = in_i.response > cats_eff;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cats_q <= CAT_W'(2);
      dims_q <= CNT_W'(1);
      covs_q <= CNT_W'(0);
    end else if (cfg_we_i) begin
      case (ncp_cfg_e'(cfg_idx_i))
        CFG_CATS: cats_q <= cfg_data_i;
        CFG_DIMS: dims_q <= cfg_data_i[CNT_W-1:0];
        CFG_COVS: covs_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-transaction operands.
  always_ff @(posedge clk_i) begin
    if (eval_acc) begin
      item_cats_q <= cats_eff;
      item_dims_q <= dims_eff;
      item_covs_q <= covs_eff;
      theta0_q    <= in_i.theta_first;
      theta1_q    <= in_i.theta_second;
      cov0_q      <= in_i.cov_first;
      cov1_q      <= in_i.cov_second;
      resp_q      <= in_i.response;
    end
  end

  // Coefficient address and operand of the read being issued.
  always_comb begin
    issue = (state_q == S_ISSUE);
    tag_d = '0;
    if (phase_cov_q) begin
      addr_full = 8'((8'(item_dims_q) + 8'd1) * 8'(item_cats_q)) + 8'(j_q);
      op_d      = (j_q == '0) ? cov0_q : cov1_q;
      tag_d.cov = 1'b1;
    end else begin
      addr_full = (d_q == '0) ? 8'(k_q) : 8'(8'(d_q) * 8'(item_cats_q)) + 8'(k_q);
      case (d_q)
        2'd0:    op_d = -16'sd4096;
        2'd1:    op_d = theta0_q;
        default: op_d = theta1_q;
      endcase
      tag_d.first = (d_q == '0);
      tag_d.last  = (d_q == item_dims_q);
      tag_d.num   = (4'(k_q) + 4'd1) == 4'(resp_q);
    end
    tag_d.valid = issue;
  end

  ncp_ram #(.WIDTH(COEF_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (in_i.coef_index),
    .wdata_i (in_i.coef_value),
    .raddr_i (addr_full[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Logit accumulation; the difficulty term starts a new category.
  assign acc_next = (tag_p_q.first ? cov_sum_q : acc_q) + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_r_q <= '0;
      tag_p_q <= '0;
      zv_q    <= 1'b0;
    end else begin
      tag_r_q <= tag_d;
      tag_p_q <= tag_r_q;
      zv_q    <= tag_p_q.valid && !tag_p_q.cov && tag_p_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    op_r_q       <= op_d;
    prod_q       <= $signed(ram_rdata) * op_r_q;
    znum_q       <= tag_p_q.num;
    if (eval_acc) begin
      cov_sum_q <= '0;
    end else if (tag_p_q.valid && tag_p_q.cov) begin
      cov_sum_q <= cov_sum_q + ACC_W'(prod_q);
    end
    if (tag_p_q.valid && !tag_p_q.cov) begin
      acc_q <= acc_next;
    end
    if (acc_next > ZLIM) begin
      z_q <= Z_W'(ZLIM);
    end else if (acc_next < -ZLIM) begin
      z_q <= Z_W'(-ZLIM);
    end else begin
      z_q <= Z_W'(acc_next);
    end
  end

  ncp_exp_chain u_exp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .z_valid_i (zv_q),
    .z_i       (z_q),
    .z_num_i   (znum_q),
    .e_valid_o (e_valid),
    .e_o       (e_val),
    .e_num_o   (e_num)
  );

  // Denominator and numerator sums.
  always_ff @(posedge clk_i) begin
    if (eval_acc) begin
      den_q <= DEN_W'(ONE_Q24);
      num_q <= (in_i.response == '0) ? DEN_W'(ONE_Q24) : '0;
    end else if (e_valid) begin
      den_q <= den_q + DEN_W'(e_val);
      if (e_num) begin
        num_q <= DEN_W'(e_val);
      end
    end
  end

  assign div_start = (state_q == S_WAIT) && (done_cnt_q == item_cats_q) && !div_busy;

  ncp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // The finished result moves into the output register once it is free.
  assign put_fire = (state_q == S_PUT) && (!out_valid_q || out_o.ready);

  // Sequencer, issue counters and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_cov_q <= 1'b0;
      k_q         <= '0;
      d_q         <= '0;
      j_q         <= '0;
      done_cnt_q  <= '0;
      res_prob_q  <= '0;
      res_bad_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_prob_q  <= '0;
      out_bad_q   <= 1'b0;
    end else begin
      if (put_fire) begin
        out_valid_q <= 1'b1;
        out_prob_q  <= res_prob_q;
        out_bad_q   <= res_bad_q;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (eval_acc) begin
        done_cnt_q <= '0;
      end else if (e_valid) begin
        done_cnt_q <= done_cnt_q + 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (eval_acc) begin
            k_q         <= '0;
            d_q         <= '0;
            j_q         <= '0;
            phase_cov_q <= (covs_eff != '0);
            if (bad_resp) begin
              res_prob_q <= '0;
              res_bad_q  <= 1'b1;
              state_q    <= S_PUT;
            end else if (cats_eff == '0) begin
              state_q <= S_WAIT;
            end else begin
              state_q <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (phase_cov_q) begin
            if (j_q == item_covs_q - 1'b1) begin
              phase_cov_q <= 1'b0;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end else if (d_q == item_dims_q) begin
            d_q <= '0;
            if (k_q == item_cats_q - 1'b1) begin
              state_q <= S_WAIT;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end else begin
            d_q <= d_q + 1'b1;
          end
        end
        S_WAIT: begin
          if (div_start) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_prob_q <= div_quot;
            res_bad_q  <= 1'b0;
            state_q    <= S_PUT;
          end
        end
        S_PUT: begin
          if (put_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.probability  = out_prob_q;
  assign out_o.bad_response = out_bad_q;

  `ASSERT_CLK(a_exp_count, clk_i, rst_ni, (state_q == S_WAIT) |-> (done_cnt_q <= item_cats_q), "more exponentials than categories")
  `ASSERT_CLK(a_bad_zero, clk_i, rst_ni, (out_valid_q && out_bad_q) |-> (out_prob_q == '0), "flagged response with nonzero probability")
  `ASSERT_NEVER(a_div_idle, clk_i, rst_ni, div_busy && (state_q != S_DIV), "divider busy outside the divide state")
  `ASSERT_NEVER(a_issue_idle, clk_i, rst_ni, tag_d.valid && in_i.ready, "coefficient read issued while taking input")

endmodule
